// File: sv/lzd_pkg.sv
// package: shared types and constants for the lz77 token decompressor
`timescale 1ns / 1ps
package lzd_pkg;
    localparam logic [7:0] MARK_LITERAL = 8'hFE;
    localparam logic [7:0] MARK_MATCH   = 8'hFD;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_OFS_OUT   = 3'd2;
    localparam logic [2:0] ST_OFS_WIN   = 3'd3;
    localparam logic [2:0] ST_LEN_LIMIT = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [15:0] skipped_markers;
        logic        run_end;
    } out_item_t;
endpackage

// File: sv/lzd_in_if.sv
// interface: input channel of compressed bytes
`timescale 1ns / 1ps
interface lzd_in_if;
    logic              valid;
    logic              ready;
    lzd_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/lzd_out_if.sv
// interface: output channel of decompressed items
`timescale 1ns / 1ps
interface lzd_out_if;
    logic               valid;
    logic               ready;
    lzd_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/lzd_history.sv
// history window memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module lzd_history #(
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// File: sv/lz77_token_decompressor_unit.sv
// top level: lz77 token stream decompressor
// usage:
//   in_ch carries one compressed byte per item plus an end_of_stream flag.
//   out_ch carries result items: data bytes (kind 0) and one end report
//   (kind 1) after the final byte of a stream; run_end marks the last
//   result caused by one input item.
// timing:
//   marker, header and literal data bytes are taken one per cycle while the
//   output is free; a data byte reaches the output register the next cycle.
//   a match's next byte holds the input for a read and a write per copied
//   byte (the history read is registered), a state for the next byte and a
//   wait state; an end report adds one more state. a faulting match is taken
//   like a header byte; any other final byte holds the input through the
//   end report and wait states. at most MAX_MATCH+2 results per item.
// stalls:
//   when out_ch.ready is low the output register holds its item and the
//   sequencer waits; no input is taken until all results of the current
//   item are delivered.
// reset:
//   rst_n clears parse state, counters and pointers at once; the history
//   memory is not cleared, a copy only reads bytes written this stream.
`timescale 1ns / 1ps
module lz77_token_decompressor_unit #(
    parameter int WINDOW    = 4096,
    parameter int MAX_MATCH = 60
) (
    input logic clk,
    input logic rst_n,
    lzd_in_if.sink    in_ch,
    lzd_out_if.source out_ch
);
    import lzd_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int PW = $clog2(WINDOW + 1);
    localparam logic [AW-1:0] WP_LAST = AW'(WINDOW - 1);

    // parse phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LITLEN  = 3'd1;
    localparam logic [2:0] PH_LITDATA = 3'd2;
    localparam logic [2:0] PH_MHDR    = 3'd3;
    localparam logic [2:0] PH_MNEXT   = 3'd4;

    // sequencer states
    localparam logic [2:0] SQ_TAKE = 3'd0;
    localparam logic [2:0] SQ_READ = 3'd1;
    localparam logic [2:0] SQ_COPY = 3'd2;
    localparam logic [2:0] SQ_NEXT = 3'd3;
    localparam logic [2:0] SQ_EOS  = 3'd4;
    localparam logic [2:0] SQ_WAIT = 3'd5;

    logic [2:0]  sq_reg, sq_next;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [31:0] ofs_reg, ofs_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] lit_reg, lit_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [2:0]  halt_reg, halt_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  nb_reg, nb_next;
    logic        eos_reg, eos_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        ov_reg, ov_next;
    out_item_t   ob_reg, ob_next;

    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    wr_data;
    logic [AW-1:0] wp_inc;

    lzd_history #(.AW(AW)) u_hist (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wp_reg),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // write pointer advance, wrapping at the window size
    assign wp_inc = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;

    // read address unit: write pointer minus offset, modulo window
    logic [AW:0] sub_a;
    always_comb
    begin
        sub_a = {1'b0, wp_reg} - {1'b0, ofs_reg[AW-1:0]};
        if (sub_a[AW])
        begin
            sub_a = sub_a + (AW+1)'(WINDOW);
        end
        rd_addr = sub_a[AW-1:0];
    end

    logic out_free;
    assign out_free    = !ov_reg || out_ch.ready;
    assign in_ch.ready = (sq_reg == SQ_TAKE) && out_free;
    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = ob_reg;

    always_comb
    begin
        logic [7:0] b;
        logic       fin;
        b = in_ch.payload.in_byte;
        fin = 1'b0;
        sq_next = sq_reg; phase_next = phase_reg; hidx_next = hidx_reg;
        ofs_next = ofs_reg; len_next = len_reg; lit_next = lit_reg;
        wp_next = wp_reg; prod_next = prod_reg; halt_next = halt_reg;
        skip_next = skip_reg; nb_next = nb_reg; eos_next = eos_reg;
        cnt_next = cnt_reg; ov_next = ov_reg; ob_next = ob_reg;
        wr_en = 1'b0; wr_data = rd_data;
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        case (sq_reg)
            SQ_TAKE:
            begin
                if (in_ch.valid && out_free)
                begin
                    eos_next = in_ch.payload.end_of_stream;
                    fin = 1'b1;
                    if (halt_reg == ST_OK)
                    begin
                        case (phase_reg)
                            PH_IDLE:
                            begin
                                if (b == MARK_LITERAL)
                                begin
                                    phase_next = PH_LITLEN; hidx_next = '0; lit_next = '0;
                                end
                                else if (b == MARK_MATCH)
                                begin
                                    phase_next = PH_MHDR; hidx_next = '0;
                                    ofs_next = '0; len_next = '0;
                                end
                                else if (skip_reg != 16'hFFFF)
                                begin
                                    skip_next = skip_reg + 16'd1;
                                end
                            end
                            PH_LITLEN:
                            begin
                                lit_next = {lit_reg[23:0], b};
                                hidx_next = hidx_reg + 4'd1;
                                if (hidx_reg == 4'd3)
                                begin
                                    hidx_next = '0;
                                    phase_next = ({lit_reg[23:0], b} != 0) ? PH_LITDATA
                                                                           : PH_IDLE;
                                end
                            end
                            PH_LITDATA:
                            begin
                                wr_en = 1'b1; wr_data = b;
                                wp_next = wp_inc;
                                if (prod_reg < PW'(WINDOW))
                                begin
                                    prod_next = prod_reg + 1'b1;
                                end
                                lit_next = lit_reg - 32'd1;
                                if (lit_reg == 32'd1)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                ov_next = 1'b1;
                                ob_next = '{1'b0, b, ST_OK, 16'd0,
                                            !in_ch.payload.end_of_stream};
                                if (in_ch.payload.end_of_stream)
                                begin
                                    fin = 1'b0; sq_next = SQ_EOS;
                                end
                            end
                            PH_MHDR:
                            begin
                                if (hidx_reg < 4'd4)
                                begin
                                    ofs_next = {ofs_reg[23:0], b};
                                end
                                else
                                begin
                                    len_next = {len_reg[23:0], b};
                                end
                                hidx_next = hidx_reg + 4'd1;
                                if (hidx_reg == 4'd7)
                                begin
                                    hidx_next = '0; phase_next = PH_MNEXT;
                                end
                            end
                            PH_MNEXT:
                            begin
                                phase_next = PH_IDLE;
                                nb_next = b;
                                if (ofs_reg > 32'(prod_reg))
                                begin
                                    halt_next = (prod_reg >= PW'(WINDOW)) ? ST_OFS_WIN
                                                                          : ST_OFS_OUT;
                                end
                                else if (len_reg > 32'(MAX_MATCH))
                                begin
                                    halt_next = ST_LEN_LIMIT;
                                end
                                else
                                begin
                                    fin = 1'b0;
                                    cnt_next = len_reg[5:0];
                                    if (ofs_reg != 0 && len_reg != 0)
                                    begin
                                        sq_next = SQ_READ;
                                    end
                                    else
                                    begin
                                        sq_next = SQ_NEXT;
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE; hidx_next = '0;
                            end
                        endcase
                        if (halt_next != ST_OK)
                        begin
                            phase_next = PH_IDLE; hidx_next = '0;
                        end
                    end
                    if (fin && in_ch.payload.end_of_stream)
                    begin
                        sq_next = SQ_EOS;
                    end
                end
            end
            SQ_READ:
            begin
                sq_next = SQ_COPY;
            end
            SQ_COPY:
            begin
                if (out_free)
                begin
                    wr_en = 1'b1; wr_data = rd_data;
                    wp_next = wp_inc;
                    if (prod_reg < PW'(WINDOW))
                    begin
                        prod_next = prod_reg + 1'b1;
                    end
                    cnt_next = cnt_reg - 6'd1;
                    ov_next = 1'b1;
                    ob_next = '{1'b0, rd_data, ST_OK, 16'd0,
                                (cnt_reg == 6'd1) && (nb_reg == 8'd0) && !eos_reg};
                    sq_next = (cnt_reg == 6'd1) ? SQ_NEXT : SQ_READ;
                end
            end
            SQ_NEXT:
            begin
                if (out_free)
                begin
                    if (nb_reg != 8'd0)
                    begin
                        wr_en = 1'b1; wr_data = nb_reg;
                        wp_next = wp_inc;
                        if (prod_reg < PW'(WINDOW))
                        begin
                            prod_next = prod_reg + 1'b1;
                        end
                        ov_next = 1'b1;
                        ob_next = '{1'b0, nb_reg, ST_OK, 16'd0, !eos_reg};
                    end
                    sq_next = eos_reg ? SQ_EOS : SQ_WAIT;
                end
            end
            SQ_EOS:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ob_next = '{1'b1, 8'd0,
                                (halt_reg == ST_OK && phase_reg != PH_IDLE) ? ST_TRUNC
                                                                           : halt_reg,
                                skip_reg, 1'b1};
                    phase_next = PH_IDLE; hidx_next = '0; ofs_next = '0;
                    len_next = '0; lit_next = '0; prod_next = '0;
                    halt_next = ST_OK; skip_next = '0;
                    sq_next = SQ_WAIT;
                end
            end
            SQ_WAIT:
            begin
                sq_next = SQ_TAKE;
            end
            default:
            begin
                sq_next = SQ_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= SQ_TAKE; phase_reg <= PH_IDLE; hidx_reg <= '0;
            ofs_reg <= '0; len_reg <= '0; lit_reg <= '0; wp_reg <= '0;
            prod_reg <= '0; halt_reg <= ST_OK; skip_reg <= '0; eos_reg <= 1'b0;
            cnt_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            sq_reg <= sq_next; phase_reg <= phase_next; hidx_reg <= hidx_next;
            ofs_reg <= ofs_next; len_reg <= len_next; lit_reg <= lit_next;
            wp_reg <= wp_next; prod_reg <= prod_next; halt_reg <= halt_next;
            skip_reg <= skip_next; eos_reg <= eos_next; cnt_reg <= cnt_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg <= nb_next;
        ob_reg <= ob_next;
    end

    a_ready_only_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> sq_reg == SQ_TAKE)
        else $error("ready outside take state");
    a_prod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= PW'(WINDOW))
        else $error("produced count above window");
    a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg != ST_OK |-> phase_reg == PH_IDLE)
        else $error("parser active while halted");
    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        sq_reg == SQ_COPY |-> cnt_reg != 6'd0)
        else $error("copy with zero count");
endmodule

// File: tb/sv/lz77_token_decompressor_unit_tb.sv
// testbench: lz77 token decompressor checked against a behavioral predictor
`timescale 1ns / 1ps
module lz77_token_decompressor_unit_tb;
    import lzd_pkg::*;

    localparam int WINDOW     = 4096;
    localparam int MAX_MATCH  = 60;
    localparam int CYCLE_CAP  = 3_000_000;
    localparam int DRAIN_WAIT = 300;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LITLEN,
        PH_LITDATA,
        PH_MHDR,
        PH_MNEXT
    } phase_t;

    // one row of the directed stimulus; a typed status is checked where given
    typedef struct {
        logic [7:0] in_byte;
        logic       eos;
        bit         has_status;
        logic [2:0] status;
    } dir_row_t;

    logic clk;
    logic rst_n;

    lzd_in_if  in_ch ();
    lzd_out_if out_ch ();

    lz77_token_decompressor_unit #(
        .WINDOW    (WINDOW),
        .MAX_MATCH (MAX_MATCH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state, mirrors the block's per-stream and history state
    phase_t      dec_phase;
    int unsigned hdr_idx;
    logic [31:0] m_ofs;
    logic [31:0] m_len;
    logic [31:0] lit_left;
    logic [7:0]  hist [WINDOW];
    int unsigned wr_ptr;
    int unsigned produced;
    logic [2:0]  halt_st;
    logic [15:0] skips;

    out_item_t   expected_q [$];
    out_item_t   stage_q [$];

    int          err_cnt;
    int          cycles;
    int          items_sent;
    int          results_seen;
    int          reports_seen;

    // clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // global cycle cap
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // queue one decompressed byte and write it into the predicted history
    task automatic put_byte(input logic [7:0] c);
        out_item_t r;
        begin
            hist[wr_ptr] = c;
            wr_ptr = (wr_ptr + 1) % WINDOW;
            if (produced < WINDOW)
                produced++;
            r = '0;
            r.data_byte = c;
            stage_q.insert(stage_q.size(), r);
        end
    endtask

    // close a match token on its next byte
    task automatic close_match(input logic [7:0] nb);
        int unsigned idx;
        begin
            dec_phase = PH_IDLE;
            if (m_ofs > produced)
                halt_st = (produced >= WINDOW) ? ST_OFS_WIN : ST_OFS_OUT;
            else if (m_len > MAX_MATCH)
                halt_st = ST_LEN_LIMIT;
            else
            begin
                // copy one byte at a time so overlapping copies repeat data
                if (m_ofs != 0)
                    for (int i = 0; i < m_len; i++)
                    begin
                        idx = (wr_ptr >= m_ofs) ? wr_ptr - m_ofs : wr_ptr + WINDOW - m_ofs;
                        put_byte(hist[idx]);
                    end
                if (nb != 8'h00)
                    put_byte(nb);
            end
        end
    endtask

    // expected results of one accepted input item
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        out_item_t r;
        begin
            stage_q.delete();
            if (halt_st == ST_OK)
            begin
                case (dec_phase)
                    PH_IDLE:
                    begin
                        if (b == MARK_LITERAL)
                        begin
                            dec_phase = PH_LITLEN;
                            hdr_idx = 0;
                            lit_left = '0;
                        end
                        else if (b == MARK_MATCH)
                        begin
                            dec_phase = PH_MHDR;
                            hdr_idx = 0;
                            m_ofs = '0;
                            m_len = '0;
                        end
                        else if (skips != 16'hFFFF)
                            skips++;
                    end
                    PH_LITLEN:
                    begin
                        lit_left = {lit_left[23:0], b};
                        hdr_idx++;
                        if (hdr_idx >= 4)
                        begin
                            hdr_idx = 0;
                            dec_phase = (lit_left != 0) ? PH_LITDATA : PH_IDLE;
                        end
                    end
                    PH_LITDATA:
                    begin
                        put_byte(b);
                        lit_left--;
                        if (lit_left == 0)
                            dec_phase = PH_IDLE;
                    end
                    PH_MHDR:
                    begin
                        if (hdr_idx < 4)
                            m_ofs = {m_ofs[23:0], b};
                        else
                            m_len = {m_len[23:0], b};
                        hdr_idx++;
                        if (hdr_idx >= 8)
                        begin
                            hdr_idx = 0;
                            dec_phase = PH_MNEXT;
                        end
                    end
                    default:
                        close_match(b);
                endcase
                if (halt_st != ST_OK)
                begin
                    dec_phase = PH_IDLE;
                    hdr_idx = 0;
                end
            end
            if (eos)
            begin
                r = '0;
                r.kind = 1'b1;
                r.status = halt_st;
                if (halt_st == ST_OK && dec_phase != PH_IDLE)
                    r.status = ST_TRUNC;
                r.skipped_markers = skips;
                stage_q.insert(stage_q.size(), r);
                dec_phase = PH_IDLE;
                hdr_idx = 0;
                m_ofs = '0;
                m_len = '0;
                lit_left = '0;
                produced = 0;
                halt_st = ST_OK;
                skips = '0;
            end
            if (stage_q.size() > 0)
                stage_q[stage_q.size() - 1].run_end = 1'b1;
            foreach (stage_q[i])
                expected_q.insert(expected_q.size(), stage_q[i]);
        end
    endtask

    // sender burst state
    int burst_left;

    // present one item and hold it until accepted; ready is sampled at the
    // falling edge, so the handshake seen is the one at the next rising edge
    task automatic send_byte(input logic [7:0] b, input logic eos);
        bit taken;
        begin
            if (burst_left == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                // some bursts are long enough to run with no gaps at all
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
            end
            burst_left--;
            in_ch.valid   <= 1'b1;
            in_ch.payload <= '{in_byte: b, end_of_stream: eos};
            do
            begin
                @(negedge clk);
                taken = in_ch.ready;
                @(posedge clk);
            end
            while (!taken);
            items_sent++;
            decode_byte(b, eos);
        end
    endtask

    // receiver: stall pattern of random runs, with stretches of full rate
    int rx_run;
    bit rx_on;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_run <= 0;
            rx_on <= 1'b1;
        end
        else if (rx_run == 0)
        begin
            rx_on <= ~rx_on;
            rx_run <= rx_on ? $urandom_range(0, 4)
                            : (($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 8));
            out_ch.ready <= ~rx_on;
        end
        else
        begin
            rx_run <= rx_run - 1;
        end
    end

    // result checker, sampled at the falling edge ahead of the handshake
    always @(negedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            results_seen++;
            if (got.kind)
                reports_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing expected: %p", got);
                err_cnt++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d actual %0d", want.kind, got.kind);
                    err_cnt++;
                end
                if (got.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h actual %0h", want.data_byte, got.data_byte);
                    err_cnt++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, got.status);
                    err_cnt++;
                end
                if (got.skipped_markers !== want.skipped_markers)
                begin
                    $error("skipped_markers: expected %0d actual %0d",
                           want.skipped_markers, got.skipped_markers);
                    err_cnt++;
                end
                if (got.run_end !== want.run_end)
                begin
                    $error("run_end: expected %0d actual %0d", want.run_end, got.run_end);
                    err_cnt++;
                end
            end
        end
    end

    // one random stream: mostly well-formed tokens, some noise, some cut short
    task automatic random_stream();
        logic [7:0]  bq [$];
        logic [31:0] ofs;
        logic [31:0] len;
        int          ntok;
        int          pick;
        int          est;
        begin
            est = produced;
            ntok = $urandom_range(1, 7);
            for (int t = 0; t < ntok; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
                    bq.insert(bq.size(), MARK_LITERAL);
                    for (int i = 3; i >= 0; i--)
                        bq.insert(bq.size(), len[i*8 +: 8]);
                    for (int i = 0; i < len; i++)
                        bq.insert(bq.size(), 8'($urandom_range(0, 255)));
                    est += len;
                end
                else if (pick < 90)
                begin
                    case ($urandom_range(0, 9))
                        0: ofs = 0;
                        1: ofs = est + 1 + $urandom_range(0, 3);
                        2: ofs = $urandom();
                        default: ofs = (est == 0) ? 0 : $urandom_range(1, est);
                    endcase
                    case ($urandom_range(0, 9))
                        0: len = MAX_MATCH;
                        1: len = MAX_MATCH + 1 + $urandom_range(0, 5);
                        2: len = $urandom();
                        default: len = $urandom_range(0, 8);
                    endcase
                    bq.insert(bq.size(), MARK_MATCH);
                    for (int i = 3; i >= 0; i--)
                        bq.insert(bq.size(), ofs[i*8 +: 8]);
                    for (int i = 3; i >= 0; i--)
                        bq.insert(bq.size(), len[i*8 +: 8]);
                    bq.insert(bq.size(), ($urandom_range(0, 3) == 0) ? 8'h00
                                                                    : 8'($urandom_range(0, 255)));
                    if (ofs <= est && len <= MAX_MATCH)
                        est += (ofs != 0 ? len : 0) + 1;
                end
                else
                    bq.insert(bq.size(), 8'($urandom_range(0, 252)));
            end
            // occasionally cut the stream inside a token
            if (bq.size() > 2 && $urandom_range(0, 7) == 0)
                bq = bq[0 : $urandom_range(1, bq.size() - 2)];
            foreach (bq[i])
                send_byte(bq[i], i == bq.size() - 1);
        end
    endtask

    dir_row_t dir_tbl [] = '{
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{MARK_LITERAL, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h02, 1'b0, 1'b0, ST_OK},
        '{8'h41, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK},
        // overlapping match: offset 1, length 3, then next byte
        '{MARK_MATCH, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h03, 1'b0, 1'b0, ST_OK},
        '{8'h43, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, ST_OK},
        // literal header cut short
        '{MARK_LITERAL, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_TRUNC},
        // match beyond the output so far, then halted until the end
        '{MARK_MATCH, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h05, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'h33, 1'b0, 1'b0, ST_OK},
        '{MARK_LITERAL, 1'b1, 1'b1, ST_OFS_OUT},
        // offset zero with a length over the limit
        '{MARK_MATCH, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h3D, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b1, 1'b1, ST_LEN_LIMIT}
    };

    int n_streams;

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        rst_n         = 1'b0;
        cycles        = 0;
        err_cnt       = 0;
        items_sent    = 0;
        results_seen  = 0;
        reports_seen  = 0;
        burst_left    = 0;
        dec_phase     = PH_IDLE;
        hdr_idx       = 0;
        m_ofs         = '0;
        m_len         = '0;
        lit_left      = '0;
        wr_ptr        = 0;
        produced      = 0;
        halt_st       = ST_OK;
        skips         = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_tbl[i])
        begin
            send_byte(dir_tbl[i].in_byte, dir_tbl[i].eos);
            if (dir_tbl[i].has_status &&
                (expected_q.size() == 0 || expected_q[$].status !== dir_tbl[i].status))
            begin
                $error("status: expected %0d actual %0d in directed row %0d",
                       dir_tbl[i].status, expected_q.size() ? expected_q[$].status : 3'd7, i);
                err_cnt++;
            end
        end

        // random streams
        n_streams = 0;
        while (items_sent < 400)
        begin
            random_stream();
            n_streams++;
        end

        in_ch.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("tb: %0d items sent: directed tokens and faults, then %0d random streams",
                 items_sent, n_streams);
        $display("tb: %0d results checked, %0d end reports among them",
                 results_seen, reports_seen);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: filelist.f
sv/lzd_pkg.sv
sv/lzd_in_if.sv
sv/lzd_out_if.sv
sv/lzd_history.sv
sv/lz77_token_decompressor_unit.sv
tb/sv/lz77_token_decompressor_unit_tb.sv
